>>> rtl/core/shadow_memory_access_checker_defines.svh
// Assertion shorthands; each use expects clk and rst_n in scope.
`ifndef SHADOW_MEMORY_ACCESS_CHECKER_DEFINES_SVH
`define SHADOW_MEMORY_ACCESS_CHECKER_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define SMAC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define SMAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/smac_pkg.sv
`default_nettype none

package smac_pkg;

  localparam int unsigned ADDR_W     = 15;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned END_W      = 17;
  localparam int unsigned OFF_W      = 3;
  localparam int unsigned GIDX_W     = END_W - OFF_W;
  localparam int unsigned GRAN_BYTES = 8;

  localparam logic [1:0] CMD_CHECK    = 2'd0;
  localparam logic [1:0] CMD_RANGE    = 2'd1;
  localparam logic [1:0] CMD_POISON   = 2'd2;
  localparam logic [1:0] CMD_UNPOISON = 2'd3;

  localparam logic ST_DONE = 1'b0;
  localparam logic ST_OOB  = 1'b1;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length;
    logic [7:0]        poison_value;
  } in_item_t;

  typedef struct packed {
    logic violation;
    logic status;
  } out_item_t;

  // Decoded request: optional head granule, body run [lo, hi), optional tail at hi.
  typedef struct packed {
    logic              oob;
    logic              is_write;
    logic              head_en;
    logic [3:0]        head_e;
    logic [GIDX_W-1:0] g0;
    logic [GIDX_W-1:0] lo;
    logic [GIDX_W-1:0] hi;
    logic              tail_en;
    logic [OFF_W-1:0]  tail_e;
    logic [7:0]        wval;
  } op_t;

endpackage

`default_nettype wire

>>> rtl/core/shadow_memory_access_checker.sv
// Fixed-size check: reads and tests a single granule.
// Ranged check: each granule visited is read, then tested.
// Poison and unpoison: 1 cycle per granule written; throughput set by
// the single-port shadow memory walked by the back-end sequencer.
// Reset: synchronous, active low; a clearing pass then zeroes every granule
// of the shadow store, with full held high throughout.
`default_nettype none

`include "shadow_memory_access_checker_defines.svh"

module shadow_memory_access_checker import smac_pkg::*; #(
  parameter int unsigned GRANULE_COUNT = 4096
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_item,
  output logic          empty,
  input  wire logic     pop,
  output out_item_t     out_item
);

  logic q_full;
  logic clearing;
  logic in_acc;
  logic op_valid;
  logic op_pop;
  op_t  op;

  assign full   = q_full | clearing;
  assign in_acc = push && !full;

  smac_front #(
    .GRANULE_COUNT(GRANULE_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (in_acc),
    .item_i    (in_item),
    .q_full_o  (q_full),
    .op_valid_o(op_valid),
    .op_o      (op),
    .op_pop_i  (op_pop)
  );

  smac_back #(
    .GRANULE_COUNT(GRANULE_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid_i(op_valid),
    .op_i      (op),
    .op_pop_o  (op_pop),
    .clearing_o(clearing),
    .empty_o   (empty),
    .pop_i     (pop),
    .item_o    (out_item)
  );

  `SMAC_ASSERT_NOW(a_pop_needs_op, op_pop, op_valid, "back end took an op from an empty queue")
  `SMAC_ASSERT_NOW(a_no_op_in_clear, clearing, !op_pop, "op taken during the clearing pass")
  `SMAC_ASSERT_NOW(a_no_result_in_clear, clearing, empty, "result present during clearing pass")
  `SMAC_ASSERT_NEXT(a_item_queued, in_acc, op_valid, "accepted item missing from op queue")

endmodule

`default_nettype wire

>>> rtl/core/smac_front.sv
`default_nettype none

module smac_front import smac_pkg::*; #(
  parameter int unsigned GRANULE_COUNT = 4096
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push_i,
  input  wire in_item_t item_i,
  output logic          q_full_o,
  output logic          op_valid_o,
  output op_t           op_o,
  input  wire logic     op_pop_i
);

  localparam int unsigned WIN_BYTES = GRANULE_COUNT * GRAN_BYTES;

  logic [END_W-1:0]  end_w;
  logic [OFF_W-1:0]  off;
  logic [OFF_W-1:0]  end_off;
  logic [GIDX_W-1:0] g0;
  logic [GIDX_W-1:0] g1;
  logic [GIDX_W-1:0] last8g;
  logic [GIDX_W-1:0] unp_hi;
  logic [3:0]        first;
  logic [3:0]        short_e;
  logic              oob;
  op_t               dec;

  assign end_w   = END_W'(item_i.address) + END_W'(item_i.length);
  assign off     = item_i.address[OFF_W-1:0];
  assign end_off = end_w[OFF_W-1:0];
  assign g0      = GIDX_W'(item_i.address[ADDR_W-1:OFF_W]);
  assign g1      = g0 + GIDX_W'(1);
  assign last8g  = end_w[END_W-1:OFF_W];
  assign unp_hi  = g0 + GIDX_W'(item_i.length[LEN_W-1:OFF_W])
                 + GIDX_W'(|item_i.length[OFF_W-1:0]);
  assign first   = 4'(GRAN_BYTES) - {1'b0, off};
  assign short_e = {1'b0, off} + item_i.length[3:0];
  assign oob     = 32'(end_w) > WIN_BYTES;

  always_comb begin
    dec      = '0;
    dec.oob  = oob;
    dec.g0   = g0;
    if (!oob && item_i.length != '0) begin
      case (item_i.cmd)
        CMD_CHECK, CMD_RANGE: begin
          if (item_i.cmd == CMD_CHECK && item_i.length inside {16'd1, 16'd2, 16'd4}) begin
            dec.head_en = 1'b1;
            dec.head_e  = short_e;
            dec.lo      = g1;
            dec.hi      = g1;
          end else if (item_i.cmd == CMD_CHECK && item_i.length == 16'd8) begin
            dec.lo = g0;
            dec.hi = g1;
          end else if (off != '0) begin
            if (item_i.length <= LEN_W'(first)) begin
              dec.head_en = 1'b1;
              dec.head_e  = short_e;
              dec.lo      = g1;
              dec.hi      = g1;
            end else begin
              dec.head_en = 1'b1;
              dec.head_e  = 4'(GRAN_BYTES);
              dec.lo      = g1;
              dec.hi      = last8g;
              dec.tail_en = end_off != '0;
              dec.tail_e  = end_off;
            end
          end else begin
            dec.lo      = g0;
            dec.hi      = last8g;
            dec.tail_en = end_off != '0;
            dec.tail_e  = end_off;
          end
        end
        CMD_POISON: begin
          dec.is_write = 1'b1;
          dec.wval     = item_i.poison_value;
          if (off != '0) begin
            // a range that ends inside its first granule writes nothing
            if (item_i.length >= LEN_W'(first)) begin
              dec.head_en = 1'b1;
              dec.head_e  = {1'b0, off};
              dec.lo      = g1;
              dec.hi      = last8g;
            end
          end else begin
            dec.lo = g0;
            dec.hi = last8g;
          end
        end
        CMD_UNPOISON: begin
          dec.is_write = 1'b1;
          dec.lo       = g0;
          dec.hi       = unp_hi;
        end
        default: begin
          dec.is_write = 1'b0;
        end
      endcase
    end
  end

  op_t        q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign q_full_o   = cnt_r == 2'd2;
  assign op_valid_o = cnt_r != 2'd0;
  assign op_o       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_i;
    rd_ptr_nxt = rd_ptr_r ^ op_pop_i;
    cnt_nxt    = cnt_r + 2'(push_i) - 2'(op_pop_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/smac_back.sv
`default_nettype none

module smac_back import smac_pkg::*; #(
  parameter int unsigned GRANULE_COUNT = 4096
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic op_valid_i,
  input  wire op_t  op_i,
  output logic      op_pop_o,
  output logic      clearing_o,
  output logic      empty_o,
  input  wire logic pop_i,
  output out_item_t item_o
);

  localparam int unsigned GW = $clog2(GRANULE_COUNT);
  localparam logic [GW-1:0] CLR_LAST = GW'(GRANULE_COUNT - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_EV    = 3'd3;
  localparam logic [2:0] S_WR    = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [1:0] SEG_HEAD = 2'd0;
  localparam logic [1:0] SEG_BODY = 2'd1;
  localparam logic [1:0] SEG_TAIL = 2'd2;

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        seg_r, seg_nxt;
  logic [GIDX_W-1:0] ptr_r, ptr_nxt;
  logic [GW-1:0]     clr_r, clr_nxt;
  op_t               op_r, op_nxt;
  logic              viol_r, viol_nxt;

  logic [7:0]        shadow_r [GRANULE_COUNT];
  logic [7:0]        rd_q_r;
  logic [GW-1:0]     mem_addr;
  logic              mem_we;
  logic [7:0]        mem_wdata;

  out_item_t         res_r [2];
  logic              res_wr_r, res_rd_r;
  logic [1:0]        res_cnt_r, res_cnt_nxt;
  logic              res_push, res_pop;

  logic [1:0]        st_seg;
  logic [GIDX_W-1:0] st_ptr;
  logic              st_fin;
  logic [1:0]        adv_seg;
  logic [GIDX_W-1:0] adv_ptr;
  logic              adv_fin;
  logic [GIDX_W-1:0] ptr_inc;
  logic [7:0]        e_ext;
  logic              part_bad;
  logic              bad;

  assign clearing_o = state_r == S_CLEAR;

  // first granule of a freshly taken request
  always_comb begin
    st_seg = SEG_HEAD;
    st_ptr = op_i.g0;
    st_fin = 1'b0;
    if (!op_i.head_en) begin
      if (op_i.lo < op_i.hi) begin
        st_seg = SEG_BODY;
        st_ptr = op_i.lo;
      end else if (op_i.tail_en) begin
        st_seg = SEG_TAIL;
        st_ptr = op_i.hi;
      end else begin
        st_fin = 1'b1;
      end
    end
  end

  assign ptr_inc = ptr_r + GIDX_W'(1);

  // step to the next granule of the request in hand
  always_comb begin
    adv_seg = seg_r;
    adv_ptr = ptr_r;
    adv_fin = 1'b0;
    case (seg_r)
      SEG_HEAD, SEG_BODY: begin
        if (seg_r == SEG_HEAD && op_r.lo < op_r.hi) begin
          adv_seg = SEG_BODY;
          adv_ptr = op_r.lo;
        end else if (seg_r == SEG_BODY && ptr_inc < op_r.hi) begin
          adv_ptr = ptr_inc;
        end else if (op_r.tail_en) begin
          adv_seg = SEG_TAIL;
          adv_ptr = op_r.hi;
        end else begin
          adv_fin = 1'b1;
        end
      end
      default: begin
        adv_fin = 1'b1;
      end
    endcase
  end

  // partial granule: bad when the valid prefix does not reach the end offset
  assign e_ext    = (seg_r == SEG_HEAD) ? {4'b0, op_r.head_e} : {5'b0, op_r.tail_e};
  assign part_bad = (rd_q_r != 8'd0) && ($signed(e_ext) > $signed(rd_q_r));
  assign bad      = (seg_r == SEG_BODY) ? (rd_q_r != 8'd0) : part_bad;

  always_comb begin
    state_nxt = state_r;
    seg_nxt   = seg_r;
    ptr_nxt   = ptr_r;
    clr_nxt   = clr_r;
    op_nxt    = op_r;
    viol_nxt  = viol_r;
    op_pop_o  = 1'b0;
    res_push  = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = 8'd0;
    case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + GW'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (op_valid_i && res_cnt_r != 2'd2) begin
          op_pop_o = 1'b1;
          op_nxt   = op_i;
          viol_nxt = 1'b0;
          if (op_i.oob || st_fin) begin
            state_nxt = S_DONE;
          end else begin
            seg_nxt   = st_seg;
            ptr_nxt   = st_ptr;
            state_nxt = op_i.is_write ? S_WR : S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_EV;
      end
      S_EV: begin
        if (bad) begin
          viol_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else if (adv_fin) begin
          state_nxt = S_DONE;
        end else begin
          seg_nxt   = adv_seg;
          ptr_nxt   = adv_ptr;
          state_nxt = S_RD;
        end
      end
      S_WR: begin
        mem_we    = 1'b1;
        mem_wdata = (seg_r == SEG_HEAD) ? {4'b0, op_r.head_e} : op_r.wval;
        if (adv_fin) begin
          state_nxt = S_DONE;
        end else begin
          seg_nxt = adv_seg;
          ptr_nxt = adv_ptr;
        end
      end
      S_DONE: begin
        res_push  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      seg_r   <= SEG_HEAD;
      ptr_r   <= '0;
      viol_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      seg_r   <= seg_nxt;
      ptr_r   <= ptr_nxt;
      viol_r  <= viol_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
  end

  assign mem_addr = (state_r == S_CLEAR) ? clr_r : GW'(ptr_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      shadow_r[mem_addr] <= mem_wdata;
    end
    rd_q_r <= shadow_r[mem_addr];
  end

  // result queue
  assign res_pop     = pop_i && (res_cnt_r != 2'd0);
  assign empty_o     = res_cnt_r == 2'd0;
  assign item_o      = res_r[res_rd_r];
  assign res_cnt_nxt = res_cnt_r + 2'(res_push) - 2'(res_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wr_r  <= 1'b0;
      res_rd_r  <= 1'b0;
      res_cnt_r <= 2'd0;
    end else begin
      res_wr_r  <= res_wr_r ^ res_push;
      res_rd_r  <= res_rd_r ^ res_pop;
      res_cnt_r <= res_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_r[res_wr_r] <= '{violation: viol_r, status: op_r.oob ? ST_OOB : ST_DONE};
    end
  end

endmodule

`default_nettype wire

>>> tb/shadow_memory_access_checker_tb.sv
module shadow_memory_access_checker_tb;
  import smac_pkg::*;

  localparam int unsigned GRANULES     = 4096;
  localparam int unsigned WINDOW_BYTES = GRANULES * GRAN_BYTES;
  localparam int unsigned OFF_MASK     = 7;
  localparam int unsigned HOLD_LEN     = 1000;
  localparam int unsigned CYCLE_LIMIT  = 2000000;

  typedef enum logic [2:0] {
    PACE_FREE,
    PACE_SEND_IDLE,
    PACE_RECV_STALL,
    PACE_BOTH,
    PACE_HOLD
  } pace_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  in_item_t  in_item = '0;
  logic      full;
  logic      empty;
  out_item_t out_item;

  shadow_memory_access_checker #(.GRANULE_COUNT(GRANULES)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  pace_t       pace = PACE_FREE;
  in_item_t    pending_requests[$];
  out_item_t   expected_verdicts[$];
  logic [7:0]  shadow_bytes [GRANULES];
  int unsigned n_offered = 0;
  int unsigned n_accepted = 0;
  int unsigned n_checked = 0;
  int unsigned fail_count = 0;
  int unsigned hold_cycles = 0;
  int unsigned cycle_count = 0;
  logic        verdict_taken = 1'b0;
  out_item_t   verdict_seen;
  out_item_t   verdict_want;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Shadow store predictor

  function automatic logic [7:0] shadow_rd(int unsigned byte_addr);
    int unsigned g;
    g = byte_addr >> 3;
    return (g < GRANULES) ? shadow_bytes[g] : 8'd0;
  endfunction

  function automatic void shadow_wr(int unsigned byte_addr, logic [7:0] v);
    int unsigned g;
    g = byte_addr >> 3;
    if (g < GRANULES) shadow_bytes[g] = v;
  endfunction

  // Valid prefix k (signed) fails to cover bytes up to end_off.
  function automatic bit prefix_short(logic [7:0] k, int end_off);
    return (k != 8'd0) && (end_off > int'($signed(k)));
  endfunction

  function automatic bit span_hits(int unsigned start, int unsigned n);
    int unsigned pos, stop, last8, next8;
    if (n == 0) return 1'b0;
    pos = start;
    stop = start + n;
    last8 = stop & ~OFF_MASK;
    if ((pos & OFF_MASK) != 0) begin
      next8 = (pos & ~OFF_MASK) + GRAN_BYTES;
      if (n <= next8 - pos) return prefix_short(shadow_rd(pos), (pos & OFF_MASK) + n);
      if (prefix_short(shadow_rd(pos), (pos & OFF_MASK) + next8 - pos)) return 1'b1;
      pos = next8;
    end
    while (pos < last8) begin
      if (shadow_rd(pos) != 8'd0) return 1'b1;
      pos += GRAN_BYTES;
    end
    if (last8 != stop) return prefix_short(shadow_rd(pos), stop - last8);
    return 1'b0;
  endfunction

  // Leave the trailing partial granule alone; skip entirely if the range ends in the head.
  function automatic void mark_poison(int unsigned start, int unsigned n, logic [7:0] pv);
    int unsigned pos, last8, next8;
    if (n == 0) return;
    pos = start;
    last8 = (start + n) & ~OFF_MASK;
    if ((pos & OFF_MASK) != 0) begin
      next8 = (pos & ~OFF_MASK) + GRAN_BYTES;
      if (n < next8 - pos) return;
      shadow_wr(pos, 8'(pos & OFF_MASK));
      pos = next8;
    end
    while (pos < last8) begin
      shadow_wr(pos, pv);
      pos += GRAN_BYTES;
    end
  endfunction

  function automatic out_item_t shadow_apply(in_item_t req);
    int unsigned a, n, pos;
    out_item_t res;
    a = req.address;
    n = req.length;
    res.violation = 1'b0;
    res.status = ST_DONE;
    if (a + n > WINDOW_BYTES) begin
      res.status = ST_OOB;
      return res;
    end
    case (req.cmd)
      CMD_CHECK: begin
        if (n == 1 || n == 2 || n == 4)
          res.violation = prefix_short(shadow_rd(a), (a & OFF_MASK) + n);
        else if (n == 8)
          res.violation = (shadow_rd(a) != 8'd0);
        else
          res.violation = span_hits(a, n);
      end
      CMD_RANGE: res.violation = span_hits(a, n);
      CMD_POISON: mark_poison(a, n, req.poison_value);
      default: begin
        for (pos = a; pos < a + n; pos += GRAN_BYTES) shadow_wr(pos, 8'd0);
      end
    endcase
    return res;
  endfunction

  // Pacing

  function automatic bit sender_idle();
    case (pace)
      PACE_SEND_IDLE: return $urandom_range(99) < 88;
      PACE_BOTH:      return $urandom_range(99) < 9;
      default:        return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (pace)
      PACE_RECV_STALL: return $urandom_range(99) < 88;
      PACE_BOTH:       return $urandom_range(99) < 9;
      PACE_HOLD:       return hold_cycles < HOLD_LEN;
      default:         return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (pace != PACE_HOLD) hold_cycles <= 0;
    else if (hold_cycles != HOLD_LEN) hold_cycles <= hold_cycles + 1;
  end

  // Driver: predict each item as it is accepted, then offer the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (!push || !full) begin
      if (push) begin
        expected_verdicts.push_back(shadow_apply(in_item));
        n_accepted <= n_accepted + 1;
      end
      if (pending_requests.size() != 0 && !sender_idle()) begin
        in_item <= pending_requests.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: register each popped item, compare on the falling edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      verdict_taken <= 1'b0;
    end else begin
      verdict_taken <= pop && !empty;
      verdict_seen <= out_item;
      pop <= !receiver_stall();
    end
  end

  always @(negedge clk) begin
    if (verdict_taken) begin
      if (expected_verdicts.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected item: violation %0b status %0b",
                   verdict_seen.violation, verdict_seen.status);
      end else begin
        verdict_want = expected_verdicts.pop_front();
        n_checked <= n_checked + 1;
        if (verdict_want.violation !== verdict_seen.violation ||
            verdict_want.status !== verdict_seen.status) begin
          fail_count++;
          if (fail_count <= 10)
            $display("item %0d: expected violation %0b status %0b, got violation %0b status %0b",
                     n_checked, verdict_want.violation, verdict_want.status,
                     verdict_seen.violation, verdict_seen.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[shadow_memory_access_checker] ERROR");
      $finish;
    end
  end

  // Stimulus

  task automatic offer(logic [1:0] cmd, int unsigned addr, int unsigned len, logic [7:0] pv);
    in_item_t req;
    req.cmd = cmd;
    req.address = addr[ADDR_W-1:0];
    req.length = len[LEN_W-1:0];
    req.poison_value = pv;
    pending_requests.push_back(req);
    n_offered++;
  endtask

  // Bias addresses into a few hot regions so poisons and checks overlap.
  task automatic offer_random(bit quick);
    int unsigned r, addr, len;
    logic [1:0] cmd;
    logic [7:0] pv;
    r = $urandom_range(19);
    if (quick || r < 7) cmd = CMD_CHECK;
    else if (r < 12) cmd = CMD_RANGE;
    else if (r < 17) cmd = CMD_POISON;
    else cmd = CMD_UNPOISON;
    case ($urandom_range(9))
      0: addr = $urandom_range(WINDOW_BYTES - 1);
      1: addr = WINDOW_BYTES - $urandom_range(1, 64);
      default: addr = $urandom_range(3) * (WINDOW_BYTES / 4) + $urandom_range(511);
    endcase
    r = $urandom_range(9);
    if (quick || (cmd == CMD_CHECK && r < 6)) len = 1 << $urandom_range(3);
    else if (r < 7) len = $urandom_range(40);
    else if (r < 9) len = $urandom_range(600);
    else if ($urandom_range(1) != 0) len = $urandom_range(65535);
    else len = $urandom_range(4000);
    case ($urandom_range(4))
      0, 1: pv = 8'h80 | 8'($urandom_range(127));
      2: pv = 8'($urandom_range(1, 7));
      default: pv = 8'($urandom_range(255));
    endcase
    offer(cmd, addr, len, pv);
  endtask

  // Hold the sender until every item offered has come back.
  task automatic wait_drained();
    while (n_accepted != n_offered || n_checked != n_accepted) @(negedge clk);
  endtask

  task automatic random_phase(pace_t p, int unsigned count, bit quick);
    @(negedge clk);
    pace = p;
    repeat (count) offer_random(quick);
    wait_drained();
  endtask

  initial begin
    foreach (shadow_bytes[i]) shadow_bytes[i] = 8'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    offer(CMD_CHECK, WINDOW_BYTES - 8, 8, 8'hFF);
    offer(CMD_RANGE, WINDOW_BYTES - 1, 0, 8'h00);
    offer(CMD_CHECK, WINDOW_BYTES - 1, 2, 8'h00);
    offer(CMD_POISON, WINDOW_BYTES - 1, 65535, 8'hFF);
    offer(CMD_POISON, WINDOW_BYTES - 1, 1, 8'hA5);
    offer(CMD_CHECK, WINDOW_BYTES - 1, 1, 8'h00);
    offer(CMD_POISON, 16, 24, 8'hFF);
    offer(CMD_CHECK, 16, 8, 8'h00);
    offer(CMD_CHECK, 25, 1, 8'h00);
    offer(CMD_RANGE, 10, 8, 8'h00);
    // range ending inside its head granule writes nothing; one ending on its boundary writes the head
    offer(CMD_POISON, 43, 3, 8'h80);
    offer(CMD_POISON, 45, 3, 8'h80);
    offer(CMD_CHECK, 41, 4, 8'h00);
    offer(CMD_CHECK, 42, 4, 8'h00);
    // odd sizes fall back to the ranged walk
    offer(CMD_CHECK, 40, 3, 8'h00);
    offer(CMD_CHECK, 40, 6, 8'h00);
    offer(CMD_POISON, 64, 8, 8'h7F);
    offer(CMD_CHECK, 64, 1, 8'h00);
    offer(CMD_CHECK, 64, 8, 8'h00);
    offer(CMD_POISON, 200, 0, 8'hFF);
    offer(CMD_CHECK, 200, 0, 8'h00);
    offer(CMD_UNPOISON, 45, 1, 8'h00);
    offer(CMD_POISON, 0, WINDOW_BYTES, 8'h80);
    offer(CMD_RANGE, 0, WINDOW_BYTES, 8'h00);
    offer(CMD_UNPOISON, 0, WINDOW_BYTES, 8'h00);
    offer(CMD_RANGE, 0, WINDOW_BYTES, 8'h00);
    wait_drained();

    random_phase(PACE_FREE, 350, 1'b0);
    random_phase(PACE_HOLD, 64, 1'b1);
    random_phase(PACE_SEND_IDLE, 350, 1'b0);
    random_phase(PACE_RECV_STALL, 350, 1'b0);
    random_phase(PACE_BOTH, 350, 1'b0);

    repeat (20) @(negedge clk);
    @(posedge clk);
    if (fail_count == 0 && expected_verdicts.size() == 0)
      $display("[shadow_memory_access_checker] OK");
    else
      $display("[shadow_memory_access_checker] ERROR");
    $finish;
  end

endmodule
